[design/segment_near_plane_clip_core_assert.svh]
// Assertion macros for the segment near-plane clip core.
// Needs clk_i and rst_ni in the scope where the macros are used.
`ifndef SEGMENT_NEAR_PLANE_CLIP_CORE_ASSERT_SVH
`define SEGMENT_NEAR_PLANE_CLIP_CORE_ASSERT_SVH

// Checked on every clock edge outside reset.
`define SNPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define SNPC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[design/snpc_pkg.sv]
// Shared widths, register codes and payload types of the near-plane clip core.
// No dependencies.
package snpc_pkg;

  localparam int COORD_W   = 32;
  localparam int FRAC_BITS = 16;
  localparam int FWD_W     = FRAC_BITS + 2;
  localparam int NEAR_W    = COORD_W - 1;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = DIFF_W + FWD_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int DEPTH_W   = SUM_W - FRAC_BITS;
  localparam int NUMDEN_W  = DEPTH_W + 1;
  localparam int ABS_W     = NUMDEN_W + 1;
  localparam int MAG_W     = NUMDEN_W;
  localparam int T_W       = FRAC_BITS + 1;
  localparam int MUL_W     = DIFF_W + T_W + 1;
  localparam int CFG_IDX_W = 32;
  localparam int NUM_REGS  = 7;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);

  localparam logic [T_W-1:0]    ONE_T      = T_W'(1) << FRAC_BITS;
  localparam logic [FWD_W-1:0]  FWD_ONE    = FWD_W'(1) << FRAC_BITS;
  localparam logic [NEAR_W-1:0] NEAR_RESET = NEAR_W'(((1 << FRAC_BITS) + 5) / 10);

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_CAMERA_X  = 3'd0,
    REG_CAMERA_Y  = 3'd1,
    REG_CAMERA_Z  = 3'd2,
    REG_FORWARD_X = 3'd3,
    REG_FORWARD_Y = 3'd4,
    REG_FORWARD_Z = 3'd5,
    REG_NEAR      = 3'd6
  } cfg_reg_e;

  // How the fraction of one segment is formed.
  typedef enum logic [1:0] {
    KIND_DEGEN = 2'd0,
    KIND_ZERO  = 2'd1,
    KIND_ONE   = 2'd2,
    KIND_DIV   = 2'd3
  } clip_kind_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] start_z;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic signed [COORD_W-1:0] end_z;
  } seg_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] clipped_x;
    logic signed [COORD_W-1:0] clipped_y;
    logic signed [COORD_W-1:0] clipped_z;
    logic [T_W-1:0]            fraction;
    logic                      degenerate;
  } seg_out_t;

  // One classified segment as it waits between front and back.
  typedef struct packed {
    logic [2:0][COORD_W-1:0] start;
    logic [2:0][DIFF_W-1:0]  dir;
    logic [MAG_W-1:0]        num;
    logic [MAG_W-1:0]        den;
    clip_kind_e              kind;
  } qent_t;

  // One step of the fraction divider.
  typedef struct packed {
    logic [MAG_W-1:0]        rem;
    logic [FRAC_BITS-1:0]    quo;
    logic [MAG_W-1:0]        den;
    logic [2:0][COORD_W-1:0] start;
    logic [2:0][DIFF_W-1:0]  dir;
    clip_kind_e              kind;
  } dstep_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

[design/snpc_front.sv]
// Front part: configuration registers, depth dot products and classification.
// Depends on snpc_pkg.
module snpc_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [snpc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [snpc_pkg::COORD_W-1:0]    cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  snpc_pkg::seg_in_t               in_data_i,
  input  snpc_pkg::qstat_t                qstat_i,
  output logic                            push_o,
  output snpc_pkg::qent_t                 push_data_o
);
  import snpc_pkg::*;

  logic signed [COORD_W-1:0] cam_q [3];
  logic signed [FWD_W-1:0]   fwd_q [3];
  logic [NEAR_W-1:0]         near_q;

  // Configuration writes; indexes past the list are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_q[0] <= '0;
      cam_q[1] <= '0;
      cam_q[2] <= '0;
      fwd_q[0] <= '0;
      fwd_q[1] <= '0;
      fwd_q[2] <= FWD_ONE;
      near_q   <= NEAR_RESET;
    end else if (cfg_valid_i && (cfg_index_i < CFG_IDX_W'(NUM_REGS))) begin
      unique case (cfg_reg_e'(cfg_index_i[2:0]))
        REG_CAMERA_X:  cam_q[0] <= cfg_data_i;
        REG_CAMERA_Y:  cam_q[1] <= cfg_data_i;
        REG_CAMERA_Z:  cam_q[2] <= cfg_data_i;
        REG_FORWARD_X: fwd_q[0] <= cfg_data_i[FWD_W-1:0];
        REG_FORWARD_Y: fwd_q[1] <= cfg_data_i[FWD_W-1:0];
        REG_FORWARD_Z: fwd_q[2] <= cfg_data_i[FWD_W-1:0];
        REG_NEAR:      near_q   <= cfg_data_i[NEAR_W-1:0];
        default: ;
      endcase
    end
  end

  // The whole front moves together unless its last stage waits on a full queue.
  logic en;
  logic [3:0] vld_q;

  assign en         = !(vld_q[3] && qstat_i.full);
  assign in_stall_o = !en;
  assign push_o     = vld_q[3] && !qstat_i.full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[2:0], in_valid_i};
    end
  end

  // Stage 1: offsets from the camera and segment direction.
  logic signed [COORD_W-1:0] sp [3];
  logic signed [COORD_W-1:0] ep [3];
  logic signed [COORD_W-1:0] s1_start_q [3];
  logic signed [DIFF_W-1:0]  s1_dir_q [3];
  logic signed [DIFF_W-1:0]  s1_rs_q [3];
  logic signed [DIFF_W-1:0]  s1_re_q [3];

  assign sp[0] = in_data_i.start_x;
  assign sp[1] = in_data_i.start_y;
  assign sp[2] = in_data_i.start_z;
  assign ep[0] = in_data_i.end_x;
  assign ep[1] = in_data_i.end_y;
  assign ep[2] = in_data_i.end_z;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s1_start_q[k] <= sp[k];
        s1_dir_q[k]   <= DIFF_W'(ep[k]) - DIFF_W'(sp[k]);
        s1_rs_q[k]    <= DIFF_W'(sp[k]) - DIFF_W'(cam_q[k]);
        s1_re_q[k]    <= DIFF_W'(ep[k]) - DIFF_W'(cam_q[k]);
      end
    end
  end

  // Stage 2: one product per axis and endpoint.
  logic signed [COORD_W-1:0] s2_start_q [3];
  logic signed [DIFF_W-1:0]  s2_dir_q [3];
  logic signed [PROD_W-1:0]  s2_ps_q [3];
  logic signed [PROD_W-1:0]  s2_pe_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s2_start_q[k] <= s1_start_q[k];
        s2_dir_q[k]   <= s1_dir_q[k];
        s2_ps_q[k]    <= PROD_W'(s1_rs_q[k]) * PROD_W'(fwd_q[k]);
        s2_pe_q[k]    <= PROD_W'(s1_re_q[k]) * PROD_W'(fwd_q[k]);
      end
    end
  end

  // Stage 3: exact sums, floored to depth.
  logic signed [SUM_W-1:0]   sum_s;
  logic signed [SUM_W-1:0]   sum_e;
  logic signed [COORD_W-1:0] s3_start_q [3];
  logic signed [DIFF_W-1:0]  s3_dir_q [3];
  logic signed [DEPTH_W-1:0] s3_ds_q;
  logic signed [DEPTH_W-1:0] s3_de_q;

  assign sum_s = SUM_W'(s2_ps_q[0]) + SUM_W'(s2_ps_q[1]) + SUM_W'(s2_ps_q[2]);
  assign sum_e = SUM_W'(s2_pe_q[0]) + SUM_W'(s2_pe_q[1]) + SUM_W'(s2_pe_q[2]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s3_start_q[k] <= s2_start_q[k];
        s3_dir_q[k]   <= s2_dir_q[k];
      end
      s3_ds_q <= $signed(sum_s[SUM_W-1:FRAC_BITS]);
      s3_de_q <= $signed(sum_e[SUM_W-1:FRAC_BITS]);
    end
  end

  // Stage 4: numerator and denominator of the crossing fraction.
  logic signed [NUMDEN_W-1:0] near_ext;
  logic signed [COORD_W-1:0]  s4_start_q [3];
  logic signed [DIFF_W-1:0]   s4_dir_q [3];
  logic signed [NUMDEN_W-1:0] s4_num_q;
  logic signed [NUMDEN_W-1:0] s4_den_q;

  assign near_ext = NUMDEN_W'(near_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s4_start_q[k] <= s3_start_q[k];
        s4_dir_q[k]   <= s3_dir_q[k];
      end
      s4_num_q <= near_ext - NUMDEN_W'(s3_ds_q);
      s4_den_q <= NUMDEN_W'(s3_de_q) - NUMDEN_W'(s3_ds_q);
    end
  end

  // Sign normalization and classification on the way into the queue.
  logic signed [ABS_W-1:0] num_w;
  logic signed [ABS_W-1:0] den_w;
  logic signed [ABS_W-1:0] num_a;
  logic signed [ABS_W-1:0] den_a;
  clip_kind_e              kind;

  always_comb begin
    num_w = ABS_W'(s4_num_q);
    den_w = ABS_W'(s4_den_q);
    num_a = s4_den_q[NUMDEN_W-1] ? -num_w : num_w;
    den_a = s4_den_q[NUMDEN_W-1] ? -den_w : den_w;
    if (s4_den_q == '0) begin
      kind = KIND_DEGEN;
    end else if (num_a[ABS_W-1] || (num_a == '0)) begin
      kind = KIND_ZERO;
    end else if (num_a >= den_a) begin
      kind = KIND_ONE;
    end else begin
      kind = KIND_DIV;
    end
    for (int k = 0; k < 3; k++) begin
      push_data_o.start[k] = s4_start_q[k];
      push_data_o.dir[k]   = s4_dir_q[k];
    end
    push_data_o.num  = num_a[MAG_W-1:0];
    push_data_o.den  = den_a[MAG_W-1:0];
    push_data_o.kind = kind;
  end

endmodule

[design/snpc_queue.sv]
// Short queue of classified segments between the front and the back.
// Depends on snpc_pkg.
module snpc_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  snpc_pkg::qent_t   push_data_i,
  input  logic              pop_i,
  output snpc_pkg::qent_t   head_o,
  output snpc_pkg::qstat_t  qstat_o
);
  import snpc_pkg::*;

  qent_t             slot_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QPTR_W:0]   count_q;

  assign qstat_o.full  = (count_q == (QPTR_W + 1)'(QDEPTH));
  assign qstat_o.empty = (count_q == '0);
  assign head_o        = slot_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      priority if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end else begin
        count_q <= count_q;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[design/snpc_back.sv]
// Back part: pipelined fraction divider, interpolation and output register.
// Depends on snpc_pkg.
module snpc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  snpc_pkg::qstat_t  qstat_i,
  input  snpc_pkg::qent_t   head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output snpc_pkg::seg_out_t out_data_o
);
  import snpc_pkg::*;

  localparam int NSTG = FRAC_BITS + 2;

  // The back moves as one unless a finished beat is held at the output.
  logic             en;
  logic [NSTG-1:0]  vld_q;

  assign en          = !(vld_q[NSTG-1] && out_stall_i);
  assign pop_o       = en && !qstat_i.empty;
  assign out_valid_o = vld_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], !qstat_i.empty};
    end
  end

  // Restoring divider, one quotient bit per stage.
  dstep_t           div_in [FRAC_BITS];
  dstep_t           div_d  [FRAC_BITS];
  dstep_t           div_q  [FRAC_BITS];
  logic [MAG_W:0]   shifted [FRAC_BITS];
  logic             ge [FRAC_BITS];

  always_comb begin
    div_in[0].rem   = head_i.num;
    div_in[0].quo   = '0;
    div_in[0].den   = head_i.den;
    div_in[0].start = head_i.start;
    div_in[0].dir   = head_i.dir;
    div_in[0].kind  = head_i.kind;
    for (int i = 1; i < FRAC_BITS; i++) begin
      div_in[i] = div_q[i-1];
    end
    for (int i = 0; i < FRAC_BITS; i++) begin
      shifted[i]   = {div_in[i].rem, 1'b0};
      ge[i]        = (shifted[i] >= {1'b0, div_in[i].den});
      div_d[i]     = div_in[i];
      div_d[i].rem = ge[i] ? MAG_W'(shifted[i] - {1'b0, div_in[i].den})
                           : shifted[i][MAG_W-1:0];
      div_d[i].quo = {div_in[i].quo[FRAC_BITS-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < FRAC_BITS; i++) begin
        div_q[i] <= div_d[i];
      end
    end
  end

  // Fraction select and one product per axis.
  dstep_t                    last;
  logic [T_W-1:0]            t_sel;
  logic signed [MUL_W-1:0]   mul_q [3];
  logic [COORD_W-1:0]        m_start_q [3];
  logic [T_W-1:0]            m_t_q;
  logic                      m_degen_q;

  assign last = div_q[FRAC_BITS-1];

  always_comb begin
    unique case (last.kind)
      KIND_DIV: t_sel = {1'b0, last.quo};
      KIND_ONE: t_sel = ONE_T;
      default:  t_sel = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        mul_q[k]     <= $signed(last.dir[k]) * $signed({1'b0, t_sel});
        m_start_q[k] <= last.start[k];
      end
      m_t_q     <= t_sel;
      m_degen_q <= (last.kind == KIND_DEGEN);
    end
  end

  // Final add and output register.
  logic [COORD_W-1:0] clip [3];
  seg_out_t           out_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      clip[k] = m_start_q[k] + mul_q[k][FRAC_BITS +: COORD_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.clipped_x  <= clip[0];
      out_q.clipped_y  <= clip[1];
      out_q.clipped_z  <= clip[2];
      out_q.fraction   <= m_t_q;
      out_q.degenerate <= m_degen_q;
    end
  end

  assign out_data_o = out_q;

endmodule

[design/segment_near_plane_clip_core.sv]
// Top level of the segment near-plane clip core.
// Depends on snpc_pkg, snpc_front, snpc_queue and snpc_back.
//
//   channel  direction  handshake            payload
//   cfg      in         cfg_valid/cfg_ready  cfg_index_i, cfg_data_i
//   in       in         in_valid/in_stall    seg_in_t
//   out      out        out_valid/out_stall  seg_out_t
//
// One segment enters and one result leaves per cycle while no output stall holds the back.
// A segment passes through 4 front stages, a slot of the 4-entry queue, and
// FRAC_BITS divider stages plus a multiply and an output stage in the back.
// Reset clears the valid bits and the queue; the configuration returns to its
// reset values. No clearing pass is needed.
// An output stall holds the back; the front keeps filling the queue and stalls
// the input only once the queue is full.
module segment_near_plane_clip_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [snpc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [snpc_pkg::COORD_W-1:0]    cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  snpc_pkg::seg_in_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output snpc_pkg::seg_out_t              out_data_o
);
  import snpc_pkg::*;

  qstat_t qstat;
  qent_t  push_data;
  qent_t  head;
  logic   push;
  logic   pop;

  snpc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .qstat_i     (qstat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  snpc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .qstat_o     (qstat)
  );

  snpc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .qstat_i     (qstat),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

[design/snpc_checker.sv]
// Port-level assertions for the segment near-plane clip core, and their bind.
// Depends on snpc_pkg and segment_near_plane_clip_core_assert.svh.
`include "segment_near_plane_clip_core_assert.svh"

module snpc_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_o,
  input  logic [snpc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [snpc_pkg::COORD_W-1:0]    cfg_data_i,
  input  logic                            in_valid_i,
  input  logic                            in_stall_o,
  input  snpc_pkg::seg_in_t               in_data_i,
  input  logic                            out_valid_o,
  input  logic                            out_stall_i,
  input  snpc_pkg::seg_out_t              out_data_o
);
  import snpc_pkg::*;

  // A stalled result beat stays and holds its payload.
  `SNPC_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o), "stalled output beat changed")

  // A degenerate segment reports a zero fraction.
  `SNPC_ASSERT(a_degen_frac, out_valid_o && out_data_o.degenerate |-> out_data_o.fraction == '0, "degenerate beat with nonzero fraction")

  // The fraction never exceeds one.
  `SNPC_ASSERT(a_frac_range, out_valid_o |-> out_data_o.fraction <= ONE_T, "fraction above one")

  // Once reset has been seen at an edge, no result is offered at the next one.
  `SNPC_ASSERT_RST(a_reset_quiet, !rst_ni |=> !out_valid_o, "output valid during reset")

endmodule

bind segment_near_plane_clip_core snpc_checker u_snpc_checker (.*);
